### rtl/sndp_pkg.sv
`timescale 1ns / 1ps

package sndp_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  // result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_FORMAT     = 4'd1;
  localparam logic [3:0] ERR_MULTITYPE  = 4'd2;
  localparam logic [3:0] ERR_NOTSAMPLED = 4'd3;
  localparam logic [3:0] ERR_MULTICMD   = 4'd4;
  localparam logic [3:0] ERR_CMD        = 4'd5;
  localparam logic [3:0] ERR_OFFSET     = 4'd6;
  localparam logic [3:0] ERR_BACKSEEK   = 4'd7;
  localparam logic [3:0] ERR_DATAOFFSET = 4'd8;
  localparam logic [3:0] ERR_ENCODING   = 4'd9;
  localparam logic [3:0] ERR_TRUNCATED  = 4'd10;

  // field values checked in the resource
  localparam logic [15:0] VERSION_ONE   = 16'h0001;
  localparam logic [15:0] VERSION_TWO   = 16'h0002;
  localparam logic [15:0] COUNT_ONE     = 16'h0001;
  localparam logic [15:0] TYPE_SAMPLED  = 16'h0005;
  localparam logic [15:0] CMD_SOUND     = 16'h8050;
  localparam logic [15:0] CMD_BUFFER    = 16'h8051;
  localparam logic [7:0]  ENC_STANDARD  = 8'h00;

  // header size from data offset through freq base
  localparam logic [32:0] HDR_BYTES = 33'd22;

  localparam int TDATA_OUT_WIDTH = 184;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  err;
    logic [7:0]  sample;
    logic        last;
    logic [31:0] count;
    logic [31:0] rate;
    logic [31:0] loop_begin;
    logic [31:0] loop_finish;
    logic [31:0] option;
    logic [1:0]  version;
    logic [7:0]  freq;
  } sndp_result_t;

endpackage

### rtl/sndp_parser.sv
`timescale 1ns / 1ps

module sndp_parser #(
  parameter int COUNT_WIDTH = sndp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    beat,
  input  logic [7:0]              byte_value,
  input  logic                    start_of_resource,
  input  logic [31:0]             resource_length,
  output logic                    res_valid,
  output sndp_pkg::sndp_result_t  res
);
  import sndp_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_FIXED   = 3'd1;
  localparam logic [2:0] PH_SKIP    = 3'd2;
  localparam logic [2:0] PH_HDR     = 3'd3;
  localparam logic [2:0] PH_SAMPLES = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [32:0] CMASK = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [2:0]             phase_r, phase_nxt;
  logic [31:0]            pos_r, pos_nxt;
  logic [31:0]            shift_r, shift_nxt;
  logic [1:0]             ver_r, ver_nxt;
  logic [31:0]            len_r, len_nxt;
  logic [31:0]            hoff_r, hoff_nxt;
  logic [32:0]            hdr_end_r, hdr_end_nxt;
  logic [31:0]            opt_r, opt_nxt;
  logic [31:0]            count_r, count_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [31:0]            lb_r, lb_nxt;
  logic [31:0]            lf_r, lf_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;

  logic [2:0]  cur_phase;
  logic [31:0] cur_pos;
  logic [31:0] shift_in;
  logic [31:0] cbase;
  logic [33:0] need;

  always_comb begin
    cur_phase = start_of_resource ? PH_FIXED : phase_r;
    cur_pos   = start_of_resource ? 32'd0 : pos_r;
    shift_in  = {(start_of_resource ? 24'd0 : shift_r[23:0]), byte_value};
    cbase     = (ver_r == 2'd1) ? 32'd10 : 32'd4;
    need      = 34'(hdr_end_r) + 34'(count_r);

    phase_nxt   = cur_phase;
    pos_nxt     = cur_pos;
    shift_nxt   = start_of_resource ? 32'd0 : shift_r;
    ver_nxt     = start_of_resource ? 2'd0 : ver_r;
    len_nxt     = start_of_resource ? resource_length : len_r;
    hoff_nxt    = hoff_r;
    hdr_end_nxt = hdr_end_r;
    opt_nxt     = start_of_resource ? 32'd0 : opt_r;
    count_nxt   = count_r;
    rate_nxt    = rate_r;
    lb_nxt      = lb_r;
    lf_nxt      = lf_r;
    left_nxt    = left_r;
    res_valid   = 1'b0;
    res         = '0;

    case (cur_phase)
      PH_FIXED: begin
        shift_nxt = shift_in;
        pos_nxt   = cur_pos + 32'd1;
        if (cur_pos == 32'd1) begin
          if (shift_in[15:0] == VERSION_ONE) begin
            ver_nxt = 2'd1;
          end else if (shift_in[15:0] == VERSION_TWO) begin
            ver_nxt = 2'd2;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_FORMAT;
            phase_nxt = PH_DONE;
          end
        end else if (cur_pos >= 32'd2) begin
          if (ver_r == 2'd1 && cur_pos == 32'd3 && shift_in[15:0] != COUNT_ONE) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_MULTITYPE;
            phase_nxt = PH_DONE;
          end else if (ver_r == 2'd1 && cur_pos == 32'd5 &&
                       shift_in[15:0] != TYPE_SAMPLED) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_NOTSAMPLED;
            phase_nxt = PH_DONE;
          end else if (ver_r == 2'd1 && cur_pos == 32'd9) begin
            opt_nxt = shift_in;
          end else if (cur_pos == cbase + 32'd1 && shift_in[15:0] != COUNT_ONE) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_MULTICMD;
            phase_nxt = PH_DONE;
          end else if (cur_pos == cbase + 32'd3 && shift_in[15:0] != CMD_SOUND &&
                       shift_in[15:0] != CMD_BUFFER) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.err   = ERR_CMD;
            phase_nxt = PH_DONE;
          end else if (cur_pos == cbase + 32'd9) begin
            hoff_nxt    = shift_in;
            hdr_end_nxt = {1'b0, shift_in} + HDR_BYTES;
            if (shift_in > len_nxt) begin
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_OFFSET;
              phase_nxt = PH_DONE;
            end else if (shift_in < cbase + 32'd10) begin
              res_valid = 1'b1;
              res.kind  = KIND_ERROR;
              res.err   = ERR_BACKSEEK;
              phase_nxt = PH_DONE;
            end else begin
              shift_nxt = 32'd0;
              if (shift_in == cbase + 32'd10) begin
                pos_nxt   = 32'd0;
                phase_nxt = PH_HDR;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end
      end

      PH_SKIP: begin
        pos_nxt = cur_pos + 32'd1;
        if (pos_nxt == hoff_r) begin
          pos_nxt   = 32'd0;
          shift_nxt = 32'd0;
          phase_nxt = PH_HDR;
        end
      end

      PH_HDR: begin
        shift_nxt = shift_in;
        pos_nxt   = cur_pos + 32'd1;
        if (cur_pos == 32'd3 && shift_in != 32'd0) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_DATAOFFSET;
          phase_nxt = PH_DONE;
        end else if (cur_pos == 32'd7) begin
          count_nxt = shift_in;
        end else if (cur_pos == 32'd11) begin
          rate_nxt = shift_in;
        end else if (cur_pos == 32'd15) begin
          lb_nxt = shift_in;
        end else if (cur_pos == 32'd19) begin
          lf_nxt = shift_in;
        end else if (cur_pos == 32'd20 && byte_value != ENC_STANDARD) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERROR;
          res.err   = ERR_ENCODING;
          phase_nxt = PH_DONE;
        end else if (cur_pos == 32'd21) begin
          res_valid = 1'b1;
          if (need > 34'(len_r) || {1'b0, count_r} > CMASK) begin
            res.kind  = KIND_ERROR;
            res.err   = ERR_TRUNCATED;
            phase_nxt = PH_DONE;
          end else begin
            res.kind        = KIND_HEADER;
            res.count       = count_r;
            res.rate        = rate_r;
            res.loop_begin  = lb_r;
            res.loop_finish = lf_r;
            res.option      = opt_r;
            res.version     = ver_r;
            res.freq        = byte_value;
            left_nxt        = count_r[COUNT_WIDTH-1:0];
            phase_nxt       = (count_r != 32'd0) ? PH_SAMPLES : PH_DONE;
          end
        end
      end

      PH_SAMPLES: begin
        res_valid  = 1'b1;
        res.kind   = KIND_SAMPLE;
        res.sample = byte_value;
        left_nxt   = left_r - COUNT_WIDTH'(1);
        if (left_r == COUNT_WIDTH'(1)) begin
          res.last  = 1'b1;
          phase_nxt = PH_DONE;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (beat) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      pos_r     <= pos_nxt;
      shift_r   <= shift_nxt;
      ver_r     <= ver_nxt;
      len_r     <= len_nxt;
      hoff_r    <= hoff_nxt;
      hdr_end_r <= hdr_end_nxt;
      opt_r     <= opt_nxt;
      count_r   <= count_nxt;
      rate_r    <= rate_nxt;
      lb_r      <= lb_nxt;
      lf_r      <= lf_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

### rtl/sndp_out_reg.sv
`timescale 1ns / 1ps

module sndp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   beat,
  input  logic                   res_valid,
  input  sndp_pkg::sndp_result_t res,
  input  logic                   out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output sndp_pkg::sndp_result_t out_res
);
  import sndp_pkg::*;

  logic         valid_r, valid_nxt;
  sndp_result_t res_r;

  // a new beat may enter when the register is empty or the held result leaves this cycle
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (beat) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### rtl/sound_resource_header_parser.sv
// Sound resource header parser. Bytes of one resource enter big-endian, one per beat, with
// in_tuser high on the first byte and the resource length in in_tdata beside it. The block
// checks the version, type and command sections, skips to the sampled-sound header, checks
// it and then returns one header result followed by the sample bytes, the final one with
// out_tlast set; any check that fails returns one error result and the rest of the resource
// is dropped. For each input byte the parser updates its state and forms at most one result
// in the same cycle, and a single output register holds that result, so a byte is accepted
// on every cycle in which the output register is empty or being drained. Results appear in
// the cycle after the byte that caused them.
`timescale 1ns / 1ps

module sound_resource_header_parser #(
  parameter int COUNT_WIDTH = sndp_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // byte_value[7:0], resource_length[39:8]
  input  logic         in_tuser,   // start_of_resource
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [183:0] out_tdata,  // error_code[3:0], sample_byte[11:4], sample_count[43:12],
                                   // rate_fixed[75:44], loop_begin[107:76],
                                   // loop_finish[139:108], init_option[171:140],
                                   // format_version[173:172], base_frequency[181:174]
  output logic [1:0]   out_tuser,  // result_kind
  output logic         out_tlast
);
  import sndp_pkg::*;

  logic         beat;
  logic         res_valid;
  sndp_result_t res;
  sndp_result_t out_res;

  assign beat = in_tvalid && in_tready;

  sndp_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat             (beat),
    .byte_value       (in_tdata[7:0]),
    .start_of_resource(in_tuser),
    .resource_length  (in_tdata[39:8]),
    .res_valid        (res_valid),
    .res              (res)
  );

  sndp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat     (beat),
    .res_valid(res_valid),
    .res      (res),
    .out_ready(out_tready),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_res  (out_res)
  );

  assign out_tdata = {2'b00, out_res.freq, out_res.version, out_res.option,
                      out_res.loop_finish, out_res.loop_begin, out_res.rate,
                      out_res.count, out_res.sample, out_res.err};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

### rtl/sndp_checker.sv
`timescale 1ns / 1ps

module sndp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [183:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);
  import sndp_pkg::*;

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  // a stalled result blocks the input side
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output register full and stalled");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR |-> out_tdata[3:0] != ERR_NONE && !out_tlast)
    else $error("error beat without code or with last");

  a_last_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_SAMPLE)
    else $error("last flag on a non-sample beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind sound_resource_header_parser sndp_checker u_sndp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sndp_pkg::*;

  localparam int ITEMS      = 400;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_WAIT  = 10;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIXED, PH_SKIP, PH_HDR, PH_SAMPLES, PH_DONE
  } phase_t;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_TYPED} check_t;

  // what goes wrong in a generated resource
  typedef enum int {
    FL_NONE, FL_VERSION, FL_TYPECOUNT, FL_TYPE, FL_CMDCOUNT, FL_CMD, FL_OFFSET,
    FL_BACKSEEK, FL_DATAOFF, FL_ENCODING, FL_SHORT_LEN, FL_HUGE_COUNT, FL_CUT,
    FL_NOISE, FL_COUNT
  } flaw_t;

  typedef struct {
    logic [7:0]  b;
    logic        s;
    logic [31:0] len;
    check_t      chk;
    logic [3:0]  err;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [183:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  sound_resource_header_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirror
  phase_t      ph = PH_IDLE;
  logic [31:0] pos_q = '0;
  logic [31:0] shift_q = '0;
  logic [1:0]  ver_q = '0;
  logic [31:0] len_q = '0;
  logic [31:0] hoff_q = '0;
  logic [31:0] opt_q = '0;
  logic [31:0] cnt_q = '0;
  logic [31:0] rate_q = '0;
  logic [31:0] lpb_q = '0;
  logic [31:0] lpe_q = '0;
  logic [31:0] left_q = '0;

  sndp_result_t pending_results[$];
  dir_row_t     dir_rows[$];
  logic [7:0]   res_bytes[$];
  logic [31:0]  res_len;

  check_t       cur_chk = CHK_MODEL;
  sndp_result_t cur_want = '0;
  bit           no_idle = 1'b0;

  int mismatches = 0;
  int parsed_bytes = 0;
  int sent_bytes = 0;
  int idle_cycles = 0;
  int n_header = 0;
  int n_sample = 0;
  int n_error = 0;
  int n_resources = 0;

  function automatic sndp_result_t error_result(input logic [3:0] code);
    sndp_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    ph = PH_DONE;
    return r;
  endfunction

  // one byte through the parser mirror; returns 1 when a result comes out
  function automatic bit parse_byte(input logic [7:0] b, input logic s, input logic [31:0] len,
                                    output sndp_result_t r);
    logic [31:0] p;
    logic [33:0] need;
    logic [63:0] cmask;
    int unsigned cbase;
    r = '0;
    if (s) begin
      ph = PH_FIXED;
      pos_q = '0;
      shift_q = '0;
      ver_q = '0;
      len_q = len;
      hoff_q = '0;
      opt_q = '0;
      cnt_q = '0;
      rate_q = '0;
      lpb_q = '0;
      lpe_q = '0;
      left_q = '0;
    end
    if (ph != PH_IDLE && ph != PH_DONE) parsed_bytes++;
    case (ph)
      PH_FIXED: begin
        shift_q = {shift_q[23:0], b};
        p = pos_q;
        pos_q = p + 1;
        if (p == 1) begin
          if (shift_q[15:0] == VERSION_ONE) ver_q = 2'd1;
          else if (shift_q[15:0] == VERSION_TWO) ver_q = 2'd2;
          else begin
            r = error_result(ERR_FORMAT);
            return 1'b1;
          end
          return 1'b0;
        end
        if (p < 2) return 1'b0;
        if (ver_q == 2'd1) begin
          if (p == 3 && shift_q[15:0] != COUNT_ONE) begin
            r = error_result(ERR_MULTITYPE);
            return 1'b1;
          end
          if (p == 5 && shift_q[15:0] != TYPE_SAMPLED) begin
            r = error_result(ERR_NOTSAMPLED);
            return 1'b1;
          end
          if (p == 9) opt_q = shift_q;
          cbase = 10;
        end else begin
          cbase = 4;
        end
        if (p == cbase + 1 && shift_q[15:0] != COUNT_ONE) begin
          r = error_result(ERR_MULTICMD);
          return 1'b1;
        end
        if (p == cbase + 3 && shift_q[15:0] != CMD_SOUND && shift_q[15:0] != CMD_BUFFER) begin
          r = error_result(ERR_CMD);
          return 1'b1;
        end
        if (p == cbase + 9) begin
          hoff_q = shift_q;
          if (hoff_q > len_q) begin
            r = error_result(ERR_OFFSET);
            return 1'b1;
          end
          if (hoff_q < cbase + 10) begin
            r = error_result(ERR_BACKSEEK);
            return 1'b1;
          end
          shift_q = '0;
          if (hoff_q == cbase + 10) begin
            pos_q = '0;
            ph = PH_HDR;
          end else begin
            ph = PH_SKIP;
          end
        end
        return 1'b0;
      end
      PH_SKIP: begin
        pos_q = pos_q + 1;
        if (pos_q == hoff_q) begin
          pos_q = '0;
          shift_q = '0;
          ph = PH_HDR;
        end
        return 1'b0;
      end
      PH_HDR: begin
        shift_q = {shift_q[23:0], b};
        p = pos_q;
        pos_q = p + 1;
        if (p == 3 && shift_q != 0) begin
          r = error_result(ERR_DATAOFFSET);
          return 1'b1;
        end
        if (p == 7) cnt_q = shift_q;
        if (p == 11) rate_q = shift_q;
        if (p == 15) lpb_q = shift_q;
        if (p == 19) lpe_q = shift_q;
        if (p == 20 && b != ENC_STANDARD) begin
          r = error_result(ERR_ENCODING);
          return 1'b1;
        end
        if (p == 21) begin
          // sum kept wide so offset plus count cannot wrap
          cmask = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
          need = {2'b00, hoff_q} + 34'd22 + {2'b00, cnt_q};
          if (need > {2'b00, len_q} || {32'b0, cnt_q} > cmask) begin
            r = error_result(ERR_TRUNCATED);
            return 1'b1;
          end
          r.kind = KIND_HEADER;
          r.count = cnt_q;
          r.rate = rate_q;
          r.loop_begin = lpb_q;
          r.loop_finish = lpe_q;
          r.option = opt_q;
          r.version = ver_q;
          r.freq = b;
          left_q = cnt_q;
          ph = (left_q != 0) ? PH_SAMPLES : PH_DONE;
          return 1'b1;
        end
        return 1'b0;
      end
      PH_SAMPLES: begin
        r.kind = KIND_SAMPLE;
        r.sample = b;
        left_q = left_q - 1;
        if (left_q == 0) begin
          r.last = 1'b1;
          ph = PH_DONE;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic string show(input sndp_result_t r);
    return $sformatf({"kind %0d err %0d smp %h last %b cnt %h rate %h lb %h lf %h",
                      " opt %h ver %0d fq %h"},
                     r.kind, r.err, r.sample, r.last, r.count, r.rate, r.loop_begin,
                     r.loop_finish, r.option, r.version, r.freq);
  endfunction

  task automatic report_bad(input string what, input sndp_result_t want, input sndp_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s at %0t", what, $time);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(got));
    end
  endtask

  // pick a 16-bit value that is neither of the two accepted ones
  function automatic logic [15:0] not_value(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] v;
    v = 16'($urandom_range(0, 16'hFFFF));
    while (v == a || v == b) v = 16'($urandom_range(0, 16'hFFFF));
    return v;
  endfunction

  task automatic push16(input logic [15:0] v);
    res_bytes.push_back(v[15:8]);
    res_bytes.push_back(v[7:0]);
  endtask

  task automatic push32(input logic [31:0] v);
    push16(v[31:16]);
    push16(v[15:0]);
  endtask

  task automatic add_row(input logic [7:0] b, input logic s, input logic [31:0] len,
                         input check_t chk, input logic [3:0] err);
    dir_row_t row;
    row.b = b;
    row.s = s;
    row.len = len;
    row.chk = chk;
    row.err = err;
    dir_rows.push_back(row);
  endtask

  // lay out one resource in res_bytes, with the requested defect
  task automatic build_resource(input flaw_t flaw);
    int unsigned cbase, skip, keep, err_at;
    logic [1:0]  ver;
    logic [31:0] off, off_field, cnt, total;
    res_bytes.delete();
    if (flaw == FL_NOISE) begin
      res_len = $urandom;
      repeat ($urandom_range(1, 8)) res_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ver = (flaw == FL_TYPECOUNT || flaw == FL_TYPE) ? 2'd1 : 2'($urandom_range(1, 2));
    cbase = (ver == 2'd1) ? 10 : 4;
    skip = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
    off = cbase + 10 + skip;
    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
    if (flaw == FL_HUGE_COUNT) cnt = 32'hFFFF_FF00 | $urandom_range(0, 255);
    total = off + 22 + cnt;
    case (flaw)
      FL_NONE, FL_CUT: begin
        case ($urandom_range(0, 3))
          0, 1:    res_len = total;
          2:       res_len = total + $urandom_range(1, 3);
          default: res_len = $urandom_range(total, 32'hFFFF_FFFF);
        endcase
      end
      FL_SHORT_LEN:  res_len = total - $urandom_range(1, 22);
      FL_HUGE_COUNT: res_len = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
      default:       res_len = total;
    endcase
    off_field = off;
    if (flaw == FL_OFFSET) begin
      off_field = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                              : $urandom_range(res_len + 1, res_len + 1000);
    end
    if (flaw == FL_BACKSEEK) off_field = $urandom_range(0, cbase + 9);

    push16((flaw == FL_VERSION) ? not_value(VERSION_ONE, VERSION_TWO)
                                : (ver == 2'd1 ? VERSION_ONE : VERSION_TWO));
    if (ver == 2'd1) begin
      push16((flaw == FL_TYPECOUNT) ? not_value(COUNT_ONE, COUNT_ONE) : COUNT_ONE);
      push16((flaw == FL_TYPE) ? not_value(TYPE_SAMPLED, TYPE_SAMPLED) : TYPE_SAMPLED);
      push32($urandom);
    end else begin
      push16(16'($urandom_range(0, 16'hFFFF)));
    end
    push16((flaw == FL_CMDCOUNT) ? not_value(COUNT_ONE, COUNT_ONE) : COUNT_ONE);
    if (flaw == FL_CMD) push16(not_value(CMD_SOUND, CMD_BUFFER));
    else push16($urandom_range(0, 1) ? CMD_SOUND : CMD_BUFFER);
    push16(16'($urandom_range(0, 16'hFFFF)));
    push32(off_field);
    repeat (skip) res_bytes.push_back(8'($urandom_range(0, 255)));
    push32((flaw == FL_DATAOFF) ? ($urandom | 32'h1) : 32'h0);
    push32(cnt);
    push32($urandom);
    push32($urandom);
    push32($urandom);
    res_bytes.push_back((flaw == FL_ENCODING) ? 8'($urandom_range(1, 255)) : ENC_STANDARD);
    res_bytes.push_back(8'($urandom_range(0, 255)));
    if (flaw == FL_NONE || flaw == FL_CUT) begin
      repeat (cnt) res_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // trailing bytes past the end are dropped by the block
    repeat ($urandom_range(0, 2)) res_bytes.push_back(8'($urandom_range(0, 255)));
    // keep only a few bytes past the one that raises the error
    case (flaw)
      FL_VERSION:             err_at = 1;
      FL_TYPECOUNT:           err_at = 3;
      FL_TYPE:                err_at = 5;
      FL_CMDCOUNT:            err_at = cbase + 1;
      FL_CMD:                 err_at = cbase + 3;
      FL_OFFSET, FL_BACKSEEK: err_at = cbase + 9;
      FL_DATAOFF:             err_at = off + 3;
      FL_ENCODING:            err_at = off + 20;
      default:                err_at = res_bytes.size();
    endcase
    keep = err_at + 1 + $urandom_range(0, 2);
    while (res_bytes.size() > keep) void'(res_bytes.pop_back());
    if (flaw == FL_CUT) begin
      keep = $urandom_range(1, res_bytes.size() - 1);
      while (res_bytes.size() > keep) void'(res_bytes.pop_back());
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic s, input logic [31:0] len,
                           input check_t chk, input sndp_result_t want);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom, 8'($urandom_range(0, 255))};
      in_tuser <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    cur_chk = chk;
    cur_want = want;
    in_tvalid <= 1'b1;
    in_tdata <= {len, b};
    in_tuser <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // result sink with random back-pressure
  initial begin : sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_draw();
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    sndp_result_t got, want, pred;
    bit has;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser;
        got.err = out_tdata[3:0];
        got.sample = out_tdata[11:4];
        got.last = out_tlast;
        got.count = out_tdata[43:12];
        got.rate = out_tdata[75:44];
        got.loop_begin = out_tdata[107:76];
        got.loop_finish = out_tdata[139:108];
        got.option = out_tdata[171:140];
        got.version = out_tdata[173:172];
        got.freq = out_tdata[181:174];
        case (got.kind)
          KIND_HEADER: n_header++;
          KIND_SAMPLE: n_sample++;
          default:     n_error++;
        endcase
        if (pending_results.size() == 0) begin
          report_bad("beat with nothing expected", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want || out_tdata[183:182] !== 2'b00) report_bad("field", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        has = parse_byte(in_tdata[7:0], in_tuser, in_tdata[39:8], pred);
        case (cur_chk)
          CHK_MODEL: if (has) pending_results.push_back(pred);
          CHK_TYPED: pending_results.push_back(cur_want);
          default: ;
        endcase
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no beat for %0d cycles, %0d results outstanding",
                   idle_cycles, pending_results.size());
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    sndp_result_t want;
    flaw_t flaw;
    int idx, flaws_done;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // byte before any start is dropped
    add_row(8'hFF, 1'b0, 32'hFFFF_FFFF, CHK_QUIET, ERR_NONE);
    // bad version, then a trailing byte
    add_row(8'h00, 1'b1, 32'h0000_0000, CHK_MODEL, ERR_NONE);
    add_row(8'h07, 1'b0, 32'hFFFF_FFFF, CHK_TYPED, ERR_FORMAT);
    add_row(8'hFF, 1'b0, 32'h0000_0000, CHK_QUIET, ERR_NONE);
    // format 1 with two types
    add_row(8'h00, 1'b1, 32'hFFFF_FFFF, CHK_MODEL, ERR_NONE);
    add_row(8'h01, 1'b0, 32'h0000_0000, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b0, 32'h0000_0000, CHK_MODEL, ERR_NONE);
    add_row(8'h02, 1'b0, 32'h0000_0000, CHK_TYPED, ERR_MULTITYPE);
    // start again in the middle, then format 2 with two commands
    add_row(8'h00, 1'b1, 32'd40, CHK_MODEL, ERR_NONE);
    add_row(8'h02, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b1, 32'd40, CHK_MODEL, ERR_NONE);
    add_row(8'h02, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'hFF, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'hFF, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h02, 1'b0, 32'd0, CHK_TYPED, ERR_MULTICMD);
    // format 2 with an unknown command
    add_row(8'h00, 1'b1, 32'd40, CHK_MODEL, ERR_NONE);
    add_row(8'h02, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h00, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h01, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h80, 1'b0, 32'd0, CHK_MODEL, ERR_NONE);
    add_row(8'h52, 1'b0, 32'd0, CHK_TYPED, ERR_CMD);

    foreach (dir_rows[i]) begin
      want = '0;
      if (dir_rows[i].chk == CHK_TYPED) begin
        want.kind = KIND_ERROR;
        want.err = dir_rows[i].err;
      end
      send_beat(dir_rows[i].b, dir_rows[i].s, dir_rows[i].len, dir_rows[i].chk, want);
    end
    wait_drained();

    // one clean resource in four, the others walk through every defect
    idx = 0;
    flaws_done = 0;
    while (sent_bytes < ITEMS || flaws_done < FL_COUNT - 1) begin
      if (idx % 4 == 0) begin
        flaw = FL_NONE;
      end else begin
        flaw = flaw_t'(1 + flaws_done % (FL_COUNT - 1));
        flaws_done++;
      end
      build_resource(flaw);
      no_idle = ($urandom_range(0, 3) == 0);
      if (idx % 4 == 3) wait_drained();
      foreach (res_bytes[i]) begin
        send_beat(res_bytes[i], i == 0, (i == 0) ? res_len : $urandom, CHK_MODEL, '0);
      end
      n_resources++;
      idx++;
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    $display("ran %0d random resources, %0d bytes sent, %0d parsed bytes",
             n_resources, sent_bytes, parsed_bytes);
    $display("saw %0d headers, %0d sample bytes, %0d errors; %0d mismatches",
             n_header, n_sample, n_error, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sndp_pkg.sv
rtl/sndp_parser.sv
rtl/sndp_out_reg.sv
rtl/sound_resource_header_parser.sv
rtl/sndp_checker.sv
test/testbench.sv
